// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tlcj_pkg.sv -----
package tlcj_pkg;

	// Fixed field widths
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned ROW_W   = 32;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned PADDR_W = 3;

	// Register word index (paddr above the byte offset)
	localparam logic [PADDR_W-3:0] REG_TOP_INDEX = '0;

	// Reset value of the top element code
	localparam logic [IDX_W-1:0] TOP_RESET = IDX_W'(1);

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_CLOSE   = 2'd1,
		OP_SUBTYPE = 2'd2,
		OP_JOIN    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_JOIN_A,
		ST_JOIN_B,
		ST_JOIN_SCAN,
		ST_ROW_PRE,
		ST_ROW_SCAN,
		ST_EMIT
	} state_t;

endpackage

// ----- sv/tlcj_if.sv -----
interface tlcj_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    opcode;
	logic [tlcj_pkg::IDX_W-1:0]    index_a;
	logic [tlcj_pkg::IDX_W-1:0]    index_b;
	logic [tlcj_pkg::ROW_W-1:0]    row_bits;

	modport source (output valid, opcode, index_a, index_b, row_bits, input ready);
	modport sink   (input valid, opcode, index_a, index_b, row_bits, output ready);
endinterface

interface tlcj_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          subtype_flag;
	logic [tlcj_pkg::IDX_W-1:0]    join_type;

	modport source (output valid, subtype_flag, join_type, input ready);
	modport sink   (input valid, subtype_flag, join_type, output ready);
endinterface

// ----- sv/type_lattice_closure_join_core.sv -----
// Type lattice closure and join engine. The relation matrix (row r = supertypes of type r)
// lives in one single-port-read, single-port-write synchronous RAM of NUM_TYPES rows, one
// row read per cycle through a registered read port; per-row valid flops make unwritten rows
// read as zero, so there is no clearing pass after reset. One command word is worked at a
// time: a join query reads row a, row b, then rows 1..NUM_TYPES-1; trivial joins and
// out-of-range queries read no row. A close runs sweeps (per row: the row itself, then every
// row j) until a sweep changes nothing, at most NUM_TYPES+2 sweeps. A finished result sits
// in an output register, so the next command word is taken while it waits. top_index is
// written over the APB port at byte address 0.
module type_lattice_closure_join_core #(
	parameter int NUM_TYPES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tlcj_cmd_if.sink                          cmd,
	tlcj_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tlcj_pkg::PADDR_W-1:0]      paddr,
	input  logic [tlcj_pkg::DATA_W-1:0]       pwdata,
	output logic [tlcj_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	localparam int unsigned AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int unsigned SW = $clog2(NUM_TYPES + 3);
	localparam int unsigned IW = tlcj_pkg::IDX_W;
	localparam logic [IW:0]     NT_L    = (IW+1)'(NUM_TYPES);
	localparam logic [AW-1:0]   LAST    = AW'(NUM_TYPES - 1);
	localparam logic [SW-1:0]   SWP_MAX = SW'(NUM_TYPES + 1);

	tlcj_pkg::state_t state_q, state_d;

	// Row memory and per-row valid flags
	logic [NUM_TYPES-1:0] row_mem [NUM_TYPES];
	logic [NUM_TYPES-1:0] vld_q;

	logic                 rd_en, wr_en;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic [NUM_TYPES-1:0] wr_data;
	logic [NUM_TYPES-1:0] rd_data_s1;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_addr_s1;
	logic [NUM_TYPES-1:0] rd_row;

	// Work registers
	logic [IW-1:0]        b_q, cand_q, cand_nx;
	logic [AW-1:0]        idx_q, j_q;
	logic [NUM_TYPES-1:0] pre_q, post_q, post_n;
	logic                 first_q, changed_q, chg_n, more;
	logic [SW-1:0]        sweep_q;
	logic                 res_flag_q;
	logic [IW-1:0]        res_join_q;
	logic [IW-1:0]        top_q;

	// Output register
	logic                 out_valid_q, out_flag_q;
	logic [IW-1:0]        out_join_q;

	logic acc, a_rng, b_rng, join_go, out_free, cand_hit, j_last, row_last;

	// Handshake and range checks
	assign acc      = cmd.valid && cmd.ready;
	assign a_rng    = {1'b0, cmd.index_a} < NT_L;
	assign b_rng    = {1'b0, cmd.index_b} < NT_L;
	assign join_go  = a_rng && b_rng && (cmd.index_a != '0) && (cmd.index_b != '0)
		&& (cmd.index_a != cmd.index_b);
	assign out_free = !out_valid_q || rsp.ready;
	assign j_last   = (j_q == LAST);
	assign row_last = (idx_q == LAST);

	// Read data: unwritten rows are zero, first sweep adds each row's own bit
	assign rd_row = (rd_vld_s1 ? rd_data_s1 : '0)
		| (first_q ? (NUM_TYPES'(1) << rd_addr_s1) : '0);

	// Closure step and sweep bookkeeping
	assign post_n = post_q | (post_q[j_q] ? rd_row : '0);
	assign chg_n  = changed_q | (post_n != pre_q);
	assign more   = chg_n && (sweep_q < SWP_MAX);

	// Join candidate step
	assign cand_hit = ({1'b0, cand_q} < NT_L) && rd_row[cand_q[AW-1:0]];
	assign cand_nx  = (post_q[idx_q] && cand_hit) ? IW'(idx_q) : cand_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlcj_pkg::ST_IDLE: begin
				if (acc) begin
					unique case (tlcj_pkg::opcode_t'(cmd.opcode))
						tlcj_pkg::OP_LOAD:    state_d = tlcj_pkg::ST_EMIT;
						tlcj_pkg::OP_CLOSE:   state_d = tlcj_pkg::ST_ROW_PRE;
						tlcj_pkg::OP_SUBTYPE: state_d = (a_rng && b_rng) ?
							tlcj_pkg::ST_SUB : tlcj_pkg::ST_EMIT;
						tlcj_pkg::OP_JOIN:    state_d = join_go ?
							tlcj_pkg::ST_JOIN_A : tlcj_pkg::ST_EMIT;
						default:              state_d = tlcj_pkg::ST_EMIT;
					endcase
				end
			end
			tlcj_pkg::ST_SUB:       state_d = tlcj_pkg::ST_EMIT;
			tlcj_pkg::ST_JOIN_A:    state_d = tlcj_pkg::ST_JOIN_B;
			tlcj_pkg::ST_JOIN_B:    state_d = tlcj_pkg::ST_JOIN_SCAN;
			tlcj_pkg::ST_JOIN_SCAN: begin
				if (row_last) state_d = tlcj_pkg::ST_EMIT;
			end
			tlcj_pkg::ST_ROW_PRE:   state_d = tlcj_pkg::ST_ROW_SCAN;
			tlcj_pkg::ST_ROW_SCAN: begin
				if (j_last) begin
					if (!row_last || more) state_d = tlcj_pkg::ST_ROW_PRE;
					else                   state_d = tlcj_pkg::ST_EMIT;
				end
			end
			tlcj_pkg::ST_EMIT: begin
				if (out_free) state_d = tlcj_pkg::ST_IDLE;
			end
			default: state_d = tlcj_pkg::ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = post_n;
		unique case (state_q)
			tlcj_pkg::ST_IDLE: begin
				wr_addr = cmd.index_a[AW-1:0];
				wr_data = cmd.row_bits[NUM_TYPES-1:0];
				rd_addr = cmd.index_a[AW-1:0];
				if (acc) begin
					unique case (tlcj_pkg::opcode_t'(cmd.opcode))
						tlcj_pkg::OP_LOAD:    wr_en = a_rng;
						tlcj_pkg::OP_CLOSE: begin
							rd_en   = 1'b1;
							rd_addr = '0;
						end
						tlcj_pkg::OP_SUBTYPE: rd_en = a_rng && b_rng;
						tlcj_pkg::OP_JOIN:    rd_en = join_go;
						default:              rd_en = 1'b0;
					endcase
				end
			end
			tlcj_pkg::ST_JOIN_A: begin
				rd_en   = 1'b1;
				rd_addr = b_q[AW-1:0];
			end
			tlcj_pkg::ST_JOIN_B: begin
				rd_en   = 1'b1;
				rd_addr = AW'(1);
			end
			tlcj_pkg::ST_JOIN_SCAN: begin
				rd_en   = !row_last;
				rd_addr = idx_q + AW'(1);
			end
			tlcj_pkg::ST_ROW_PRE: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			tlcj_pkg::ST_ROW_SCAN: begin
				if (!j_last) begin
					rd_en   = 1'b1;
					rd_addr = j_q + AW'(1);
				end else begin
					wr_en   = 1'b1;
					rd_en   = !row_last || more;
					rd_addr = row_last ? '0 : idx_q + AW'(1);
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Row memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) row_mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_data_s1 <= row_mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	// Valid flags and read-side valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (rd_en) rd_vld_s1 <= vld_q[rd_addr];
			if (wr_en) vld_q[wr_addr] <= 1'b1;
		end
	end

	// State and close control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tlcj_pkg::ST_IDLE;
			first_q   <= 1'b0;
			changed_q <= 1'b0;
			sweep_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tlcj_pkg::ST_IDLE && acc
				&& tlcj_pkg::opcode_t'(cmd.opcode) == tlcj_pkg::OP_CLOSE) begin
				first_q   <= 1'b1;
				changed_q <= 1'b0;
				sweep_q   <= '0;
			end else if (state_q == tlcj_pkg::ST_ROW_SCAN && j_last) begin
				if (row_last) begin
					first_q   <= 1'b0;
					changed_q <= 1'b0;
					sweep_q   <= sweep_q + SW'(1);
				end else begin
					changed_q <= chg_n;
				end
			end
		end
	end

	// Work datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			tlcj_pkg::ST_IDLE: begin
				if (acc) begin
					b_q        <= cmd.index_b;
					idx_q      <= '0;
					res_flag_q <= 1'b0;
					res_join_q <= '0;
					// Join of a code with itself answers that code
					if (tlcj_pkg::opcode_t'(cmd.opcode) == tlcj_pkg::OP_JOIN && a_rng && b_rng
						&& cmd.index_a == cmd.index_b)
						res_join_q <= cmd.index_a;
				end
			end
			tlcj_pkg::ST_SUB: begin
				res_flag_q <= rd_row[b_q[AW-1:0]];
			end
			tlcj_pkg::ST_JOIN_A: begin
				post_q <= rd_row;
			end
			tlcj_pkg::ST_JOIN_B: begin
				post_q <= post_q & rd_row;
				idx_q  <= AW'(1);
				cand_q <= top_q;
			end
			tlcj_pkg::ST_JOIN_SCAN: begin
				cand_q     <= cand_nx;
				idx_q      <= idx_q + AW'(1);
				res_join_q <= cand_nx;
			end
			tlcj_pkg::ST_ROW_PRE: begin
				pre_q  <= rd_row;
				post_q <= rd_row;
				j_q    <= '0;
			end
			tlcj_pkg::ST_ROW_SCAN: begin
				post_q <= post_n;
				j_q    <= j_q + AW'(1);
				if (j_last) idx_q <= row_last ? '0 : idx_q + AW'(1);
			end
			default: begin
				res_flag_q <= res_flag_q;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tlcj_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tlcj_pkg::ST_EMIT && out_free) begin
			out_flag_q <= res_flag_q;
			out_join_q <= res_join_q;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= tlcj_pkg::TOP_RESET;
		end else if (psel && penable && pwrite
			&& paddr[tlcj_pkg::PADDR_W-1:2] == tlcj_pkg::REG_TOP_INDEX) begin
			top_q <= pwdata[IW-1:0];
		end
	end

	assign prdata = (paddr[tlcj_pkg::PADDR_W-1:2] == tlcj_pkg::REG_TOP_INDEX) ?
		tlcj_pkg::DATA_W'(top_q) : '0;
	assign pready = 1'b1;

	assign cmd.ready        = (state_q == tlcj_pkg::ST_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.subtype_flag = out_flag_q;
	assign rsp.join_type    = out_join_q;

endmodule

// ----- sv/tlcj_checker.sv -----
`include "assert_macros.svh"

module tlcj_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_subtype_flag,
	input logic [tlcj_pkg::IDX_W-1:0]   rsp_join_type
);

	// One command word in flight: ready drops right after an accept
	`CHK_NEXT(a_one_word, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready, "ready held after accept")

	// A result never carries both a subtype flag and a join code
	`CHK_IMPLY(a_excl_fields, clk, arst_n, rsp_valid, !(rsp_subtype_flag && (rsp_join_type != '0)), "flag and join both set")

	// Stalled result stays put
	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_subtype_flag) && $stable(rsp_join_type), "stalled result changed")

endmodule

bind type_lattice_closure_join_core tlcj_checker u_tlcj_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_subtype_flag (rsp.subtype_flag),
	.rsp_join_type    (rsp.join_type)
);
